### rtl/core/ogdi_pkg.sv
// types and constants shared by the occupancy grid disk inflation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ogdi_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CFG_WIDTH       = 11;
   localparam int RADIUS_WIDTH    = 4;
   localparam int ROW_WIDTH       = 11;
   localparam int COORD_WIDTH     = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS      = 2'd2;

   localparam logic [ROW_WIDTH-1:0] ROW_LIMIT = 11'd2047;

   localparam logic [CFG_WIDTH-1:0]    GRID_WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_WIDTH-1:0]    GRID_HEIGHT_RESET = 11'd1024;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET      = 4'd1;

   typedef struct packed {
      logic req_type;
      logic occupied;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] out_row;
      logic [COORD_WIDTH-1:0] out_col;
      logic                   is_free;
      logic                   last_cell;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/core/occupancy_grid_disk_inflation.sv
// Occupancy grid disk inflation: one cell per request transaction in raster order, the cell
// radius rows plus radius cells back is reported free when no obstacle lies in the disk
// around it. A stored cell ring of (2*MAX_RADIUS+1)*(MAX_WIDTH+1) one-bit entries in a
// single-port memory holds the stream; its contents are undefined after reset and there is
// no clearing pass, so every frame must be closed by radius*grid_width+radius padding
// transactions. A transaction that yields a response waits in ST_RESULT while the previous
// response is still held, stalled, in the output register. Each stream position is reduced
// modulo the ring depth by a reciprocal multiplication in ST_MOD and a multiply-subtract in
// ST_REDUCE. The disk window is read one cell per cycle through the single memory read port.
// A pending response sits in an output register, so the next request is taken while it
// waits. Register writes are taken only while no request transaction is being worked on.
// depends on ogdi_pkg
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_disk_inflation
   import ogdi_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RB    = (HW > ROW_WIDTH) ? HW : ROW_WIDTH;
   localparam int PW    = RB + WW;
   localparam int DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int SHIFT = PW + AW;
   localparam int MW    = PW + 2;
   localparam int QW    = PW - AW + 2;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + longint'(DEPTH) - 64'd1) / longint'(DEPTH);
   localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
   localparam int YW    = $clog2(MAX_HEIGHT) + 3;
   localparam int XW    = $clog2(MAX_WIDTH) + 3;
   localparam int DW    = 2 * RW + 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SUM,
      ST_MOD,
      ST_REDUCE,
      ST_WRITE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type state_ff;

   logic [CFG_WIDTH-1:0]    grid_width_ff;
   logic [CFG_WIDTH-1:0]    grid_height_ff;
   logic [RADIUS_WIDTH-1:0] radius_ff;

   logic [ROW_WIDTH-1:0] in_row_ff;
   logic [CW-1:0]        in_col_ff;
   logic [HW-1:0]        out_row_ff;
   logic [CW-1:0]        out_col_ff;

   logic            occ_ff;
   logic [PW-1:0]   prod_ff;
   logic [PW-1:0]   cprod_ff;
   logic [PW-1:0]   thresh_ff;
   logic [2*RW-1:0] lim_ff;
   logic [PW-1:0]   pos_ff;
   logic [PW-1:0]   cval_ff;
   logic [PW-1:0]   rem_ff;
   logic [QW-1:0]   quo_ff;
   logic            phase_ff;

   logic [AW-1:0]     row_addr_ff;
   logic [AW-1:0]     addr_ff;
   logic signed [RW:0] dy_ff;
   logic signed [RW:0] dx_ff;
   logic              chk_ff;
   logic              hit_ff;
   logic              rd_data_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic mem_array [DEPTH];

   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [RW-1:0]      r_eff;
   logic signed [RW:0] r_s;

   logic [WW-1:0]        in_col_inc;
   logic                 in_wrap;
   logic [CW-1:0]        in_col_in;
   logic [ROW_WIDTH-1:0] in_row_in;
   logic [WW-1:0]        out_col_inc;
   logic                 out_wrap;
   logic [CW-1:0]        out_col_in;
   logic [HW-1:0]        out_row_in;
   logic                 out_off_grid;
   logic                 last_w;
   logic                 pad_w;
   logic                 emit_w;
   logic                 rsp_load;

   logic [PW+MW-1:0] recip_prod;
   logic [PW-1:0]    quo_mul;
   logic [AW:0]   start_addr;
   logic [AW:0]   row_sum;
   logic [AW-1:0] row_step;
   logic [AW-1:0] col_step;

   logic signed [DW-1:0] dy_w;
   logic signed [DW-1:0] dx_w;
   logic signed [DW-1:0] dist_w;
   logic signed [DW-1:0] lim_w;
   logic signed [YW-1:0] y_w;
   logic signed [XW-1:0] x_w;
   logic                 in_disk;
   logic                 in_grid;

   // effective configuration
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(grid_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(grid_height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(grid_height_ff);
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
   end

   assign r_s = $signed({1'b0, r_eff});

   // stream counters
   assign in_col_inc = WW'(in_col_ff) + WW'(1);
   assign in_wrap    = (in_col_inc >= w_eff);
   assign in_col_in  = in_wrap ? '0 : CW'(in_col_inc);
   assign in_row_in  = (in_wrap && (in_row_ff != ROW_LIMIT)) ?
                       in_row_ff + ROW_WIDTH'(1) : in_row_ff;

   assign out_col_inc  = WW'(out_col_ff) + WW'(1);
   assign out_wrap     = (out_col_inc >= w_eff);
   assign out_col_in   = out_wrap ? '0 : CW'(out_col_inc);
   assign out_row_in   = out_wrap ? out_row_ff + HW'(1) : out_row_ff;
   assign out_off_grid = (out_row_ff >= h_eff) || (WW'(out_col_ff) >= w_eff);
   assign last_w       = (out_row_ff == h_eff - HW'(1)) &&
                         (WW'(out_col_ff) == w_eff - WW'(1));

   assign pad_w  = req_payload.req_type || (RB'(in_row_ff) >= RB'(h_eff));
   assign emit_w = (pos_ff >= thresh_ff);

   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // ring depth reduction by reciprocal multiplication
   assign recip_prod = (PW + MW)'(rem_ff) * (PW + MW)'(RECIP);
   assign quo_mul    = PW'(quo_ff) * PW'(DEPTH);

   // ring address arithmetic
   always_comb begin
      if ((AW + 1)'(rem_ff[AW-1:0]) >= (AW + 1)'(thresh_ff[AW-1:0])) begin
         start_addr = (AW + 1)'(rem_ff[AW-1:0]) - (AW + 1)'(thresh_ff[AW-1:0]);
      end else begin
         start_addr = (AW + 1)'(rem_ff[AW-1:0]) + (AW + 1)'(DEPTH) -
                      (AW + 1)'(thresh_ff[AW-1:0]);
      end
      row_sum = (AW + 1)'(row_addr_ff) + (AW + 1)'(w_eff);
      if (row_sum >= (AW + 1)'(DEPTH)) begin
         row_step = AW'(row_sum - (AW + 1)'(DEPTH));
      end else begin
         row_step = AW'(row_sum);
      end
      if ((AW + 1)'(addr_ff) == (AW + 1)'(DEPTH - 1)) begin
         col_step = '0;
      end else begin
         col_step = addr_ff + AW'(1);
      end
   end

   // disk and grid membership of the current window cell
   assign dy_w    = DW'(dy_ff);
   assign dx_w    = DW'(dx_ff);
   assign dist_w  = dy_w * dy_w + dx_w * dx_w;
   assign lim_w   = $signed(DW'(lim_ff));
   assign y_w     = $signed(YW'(out_row_ff)) + YW'(dy_ff);
   assign x_w     = $signed(XW'(out_col_ff)) + XW'(dx_ff);
   assign in_disk = (dist_w <= lim_w);
   assign in_grid = (y_w >= $signed(YW'(0))) && (y_w < $signed(YW'(h_eff))) &&
                    (x_w >= $signed(XW'(0))) && (x_w < $signed(XW'(w_eff)));

   // cell ring
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         mem_array[rem_ff[AW-1:0]] <= occ_ff;
      end
      if (state_ff == ST_SCAN) begin
         rd_data_ff <= mem_array[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         radius_ff      <= RADIUS_RESET;
         in_row_ff      <= '0;
         in_col_ff      <= '0;
         out_row_ff     <= '0;
         out_col_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         chk_ff         <= 1'b0;
         hit_ff         <= 1'b0;
         phase_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
               CSR_RADIUS:      radius_ff      <= csr_wdata[RADIUS_WIDTH-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         chk_ff <= (state_ff == ST_SCAN) && in_disk && in_grid;
         if (state_ff == ST_START) begin
            hit_ff <= 1'b0;
         end else begin
            hit_ff <= hit_ff | (chk_ff & rd_data_ff);
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  occ_ff   <= !pad_w && req_payload.occupied;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               prod_ff   <= PW'(in_row_ff) * PW'(w_eff);
               cprod_ff  <= PW'(out_row_ff) * PW'(w_eff);
               thresh_ff <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
               lim_ff    <= (2 * RW)'(r_eff) * (2 * RW)'(r_eff);
               state_ff  <= ST_SUM;
            end
            ST_SUM: begin
               pos_ff   <= prod_ff + PW'(in_col_ff);
               rem_ff   <= prod_ff + PW'(in_col_ff);
               cval_ff  <= cprod_ff + PW'(out_col_ff);
               phase_ff <= 1'b0;
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               quo_ff   <= QW'(recip_prod >> SHIFT);
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               rem_ff   <= rem_ff - quo_mul;
               state_ff <= phase_ff ? ST_START : ST_WRITE;
            end
            ST_WRITE: begin
               if (!emit_w) begin
                  in_col_ff <= in_col_in;
                  in_row_ff <= in_row_in;
                  state_ff  <= ST_IDLE;
               end else if (out_off_grid) begin
                  in_row_ff  <= '0;
                  in_col_ff  <= '0;
                  out_row_ff <= '0;
                  out_col_ff <= '0;
                  state_ff   <= ST_IDLE;
               end else begin
                  rem_ff   <= cval_ff;
                  phase_ff <= 1'b1;
                  state_ff <= ST_MOD;
               end
            end
            ST_START: begin
               row_addr_ff <= AW'(start_addr);
               addr_ff     <= AW'(start_addr);
               dy_ff       <= -r_s;
               dx_ff       <= -r_s;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               if (dx_ff == r_s) begin
                  dx_ff       <= -r_s;
                  dy_ff       <= dy_ff + $signed((RW + 1)'(1));
                  row_addr_ff <= row_step;
                  addr_ff     <= row_step;
                  if (dy_ff == r_s) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  dx_ff   <= dx_ff + $signed((RW + 1)'(1));
                  addr_ff <= col_step;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (rsp_load) begin
                  rsp_payload_ff.out_row   <= COORD_WIDTH'(out_row_ff);
                  rsp_payload_ff.out_col   <= COORD_WIDTH'(out_col_ff);
                  rsp_payload_ff.is_free   <= !hit_ff;
                  rsp_payload_ff.last_cell <= last_w;
                  if (last_w) begin
                     in_row_ff  <= '0;
                     in_col_ff  <= '0;
                     out_row_ff <= '0;
                     out_col_ff <= '0;
                  end else begin
                     out_col_ff <= out_col_in;
                     out_row_ff <= out_row_in;
                     in_col_ff  <= in_col_in;
                     in_row_ff  <= in_row_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = (state_ff == ST_IDLE);

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE || state_ff == ST_START) |-> (rem_ff < PW'(DEPTH)))
      else $error("ring address not reduced below depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((AW + 1)'(addr_ff) < (AW + 1)'(DEPTH)))
      else $error("window read address outside ring");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && rsp_valid_ff && rsp_stall) |=>
      (state_ff == ST_RESULT && $stable(rsp_payload_ff)))
      else $error("pending response overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_w) |=>
      (in_row_ff == '0 && in_col_ff == '0 && out_row_ff == '0 && out_col_ff == '0))
      else $error("frame end did not clear stream counters");

endmodule

`default_nettype wire

### dv/tb_occupancy_grid_disk_inflation.sv
// self-checking testbench for occupancy_grid_disk_inflation: framed grids in raster order,
// a transaction-level predictor of the disk test and an in-order check of every result transaction
// depends on ogdi_pkg and occupancy_grid_disk_inflation
`timescale 1ns / 1ps

module tb_occupancy_grid_disk_inflation;
   import ogdi_pkg::*;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MAX_RADIUS   = 8;
   localparam int STORE_DEPTH  = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
   localparam int QUIET_CYCLES = 360;

   // register index with no register behind it
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      bit                         is_csr;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CFG_WIDTH-1:0]       wdata;
      req_payload_type            payload;
   } stim_entry_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_wdata = '0;

   occupancy_grid_disk_inflation #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // stimulus stream and expected cell reports
   stim_entry_type  cell_stream[$];
   rsp_payload_type awaited_cells[$];

   // builder shadow of the registers
   logic [CFG_WIDTH-1:0]    shadow_width  = GRID_WIDTH_RESET;
   logic [CFG_WIDTH-1:0]    shadow_height = GRID_HEIGHT_RESET;
   logic [RADIUS_WIDTH-1:0] shadow_radius = RADIUS_RESET;

   // predictor state
   logic [CFG_WIDTH-1:0]    cfg_width;
   logic [CFG_WIDTH-1:0]    cfg_height;
   logic [RADIUS_WIDTH-1:0] cfg_radius;
   logic [ROW_WIDTH-1:0]    stream_row;
   logic [COORD_WIDTH-1:0]  stream_col;
   logic [COORD_WIDTH-1:0]  report_row;
   logic [COORD_WIDTH-1:0]  report_col;
   bit                      occ_ring[STORE_DEPTH];

   int unsigned total_items   = 0;
   int unsigned sent_count    = 0;
   int unsigned csr_writes    = 0;
   int unsigned frames_queued = 0;
   int unsigned frames_done   = 0;
   int unsigned cells_checked = 0;
   int unsigned fail_count    = 0;
   int unsigned quiet_count   = 0;
   int unsigned send_idle_pct = 24;
   int unsigned rsp_idle_pct  = 71;
   longint unsigned cycle_count  = 0;
   longint unsigned limit_budget = 0;
   longint unsigned cycle_limit  = 0;
   bit stim_done = 1'b0;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      stream_row = '0;
      stream_col = '0;
      report_row = '0;
      report_col = '0;
   endfunction

   function automatic void predict_inflation(req_payload_type grid_item);
      int unsigned w, h, r, pos;
      int y, x, dy, dx, reach;
      bit pad, free;
      rsp_payload_type want;
      w = clamp_to(cfg_width, 1, MAX_WIDTH);
      h = clamp_to(cfg_height, 1, MAX_HEIGHT);
      r = clamp_to(cfg_radius, 0, MAX_RADIUS);
      pos = stream_row * w + stream_col;
      pad = grid_item.req_type || stream_row >= h;
      occ_ring[pos % STORE_DEPTH] = !pad && grid_item.occupied;
      if (pos >= r * w + r) begin
         if (report_row >= h || report_col >= w) begin
            restart_frame();
            return;
         end
         free = 1'b1;
         reach = r;
         for (dy = -reach; dy <= reach; dy++) begin
            for (dx = -reach; dx <= reach; dx++) begin
               y = int'(report_row) + dy;
               x = int'(report_col) + dx;
               if (dy * dy + dx * dx <= reach * reach && y >= 0 && y < int'(h) &&
                   x >= 0 && x < int'(w) && occ_ring[(y * int'(w) + x) % STORE_DEPTH])
                  free = 1'b0;
            end
         end
         want.out_row   = report_row;
         want.out_col   = report_col;
         want.is_free   = free;
         want.last_cell = (report_row == h - 1) && (report_col == w - 1);
         awaited_cells.insert(awaited_cells.size(), want);
         if (want.last_cell) begin
            restart_frame();
            return;
         end
         if (report_col + 1 >= w) begin
            report_col = '0;
            report_row = report_row + 1'b1;
         end else begin
            report_col = report_col + 1'b1;
         end
      end
      if (stream_col + 1 >= w) begin
         stream_col = '0;
         if (stream_row < ROW_LIMIT) stream_row = stream_row + 1'b1;
      end else begin
         stream_col = stream_col + 1'b1;
      end
   endfunction

   task automatic queue_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] value);
      stim_entry_type e;
      e.is_csr  = 1'b1;
      e.index   = index;
      e.wdata   = value;
      e.payload = '0;
      cell_stream.insert(cell_stream.size(), e);
      case (index)
         CSR_GRID_WIDTH:  shadow_width  = value;
         CSR_GRID_HEIGHT: shadow_height = value;
         CSR_RADIUS:      shadow_radius = value[RADIUS_WIDTH-1:0];
         default: ;
      endcase
      limit_budget += QUIET_CYCLES + 20;
   endtask

   // one whole frame: any register writes, grid cells, then the trailing padding that flushes it
   task automatic queue_frame(logic [CFG_WIDTH-1:0] w_raw, logic [CFG_WIDTH-1:0] h_raw,
                              logic [RADIUS_WIDTH-1:0] r_raw, int density, int lone,
                              int grid_pad_pct, int tail_cell_pct);
      stim_entry_type e;
      int unsigned w, h, r, i;
      if (w_raw != shadow_width || $urandom_range(3) == 0) queue_csr(CSR_GRID_WIDTH, w_raw);
      if (h_raw != shadow_height || $urandom_range(3) == 0) queue_csr(CSR_GRID_HEIGHT, h_raw);
      if (r_raw != shadow_radius || $urandom_range(3) == 0) queue_csr(CSR_RADIUS, r_raw);
      w = clamp_to(shadow_width, 1, MAX_WIDTH);
      h = clamp_to(shadow_height, 1, MAX_HEIGHT);
      r = clamp_to(shadow_radius, 0, MAX_RADIUS);
      e.is_csr = 1'b0;
      e.index  = '0;
      e.wdata  = '0;
      for (i = 0; i < w * h + r * w + r; i++) begin
         if (i < w * h) begin
            e.payload.req_type = ($urandom_range(99) < grid_pad_pct);
            e.payload.occupied = (lone >= 0) ? (i == lone) : ($urandom_range(99) < density);
         end else begin
            e.payload.req_type = !($urandom_range(99) < tail_cell_pct);
            e.payload.occupied = 1'($urandom_range(1));
         end
         cell_stream.insert(cell_stream.size(), e);
         total_items++;
         limit_budget += 56 + (2 * r + 1) * (2 * r + 1);
      end
      frames_queued++;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      stim_entry_type head;
      bit req_busy, csr_busy, next_req_valid, next_csr_valid;
      if (reset) begin
         req_valid   <= 1'b0;
         csr_valid   <= 1'b0;
         quiet_count <= 0;
         stim_done   <= 1'b0;
      end else begin
         if (req_valid && !req_stall) sent_count++;
         if (sent_count * 3 < total_items) begin
            send_idle_pct = 24;
            rsp_idle_pct  = 71;
         end else if (sent_count * 3 < total_items * 2) begin
            send_idle_pct = 71;
            rsp_idle_pct  = 24;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         req_busy = req_valid && req_stall;
         csr_busy = csr_valid && !csr_ready;
         if (req_valid || awaited_cells.size() != 0) quiet_count <= 0;
         else if (quiet_count < QUIET_CYCLES) quiet_count <= quiet_count + 1;
         next_req_valid = req_busy;
         next_csr_valid = csr_busy;
         if (!req_busy && !csr_busy && cell_stream.size() != 0) begin
            head = cell_stream[0];
            if (head.is_csr) begin
               // registers only change once the block has drained
               if (!req_valid && quiet_count >= QUIET_CYCLES) begin
                  csr_index      <= head.index;
                  csr_wdata      <= head.wdata;
                  next_csr_valid = 1'b1;
                  void'(cell_stream.pop_front());
               end
            end else if ($urandom_range(99) >= send_idle_pct) begin
               req_payload    <= head.payload;
               next_req_valid = 1'b1;
               void'(cell_stream.pop_front());
            end
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;
         stim_done <= cell_stream.size() == 0 && !next_req_valid && !next_csr_valid;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rsp_payload_type want;
      cycle_count++;
      if (reset) begin
         cfg_width  = GRID_WIDTH_RESET;
         cfg_height = GRID_HEIGHT_RESET;
         cfg_radius = RADIUS_RESET;
         restart_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_cells.size() == 0) begin
               $error("unexpected result transaction row %0d col %0d",
                      rsp_payload.out_row, rsp_payload.out_col);
               fail_count++;
            end else begin
               want = awaited_cells.pop_front();
               cells_checked++;
               if (rsp_payload.out_row !== want.out_row) begin
                  $error("out_row mismatch: expected %0d, got %0d",
                         want.out_row, rsp_payload.out_row);
                  fail_count++;
               end
               if (rsp_payload.out_col !== want.out_col) begin
                  $error("out_col mismatch: expected %0d, got %0d",
                         want.out_col, rsp_payload.out_col);
                  fail_count++;
               end
               if (rsp_payload.is_free !== want.is_free) begin
                  $error("is_free mismatch: expected %0d, got %0d",
                         want.is_free, rsp_payload.is_free);
                  fail_count++;
               end
               if (rsp_payload.last_cell !== want.last_cell) begin
                  $error("last_cell mismatch: expected %0d, got %0d",
                         want.last_cell, rsp_payload.last_cell);
                  fail_count++;
               end
               if (want.last_cell) frames_done++;
            end
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_GRID_WIDTH:  cfg_width  = csr_wdata;
               CSR_GRID_HEIGHT: cfg_height = csr_wdata;
               CSR_RADIUS:      cfg_radius = csr_wdata[RADIUS_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_inflation(req_payload);
      end
   end

   initial begin
      int unsigned w_pick, h_pick, r_pick, density;
      bit timed_out;

      // directed: unused index, lone obstacle, clamped minimum sizes, clamped radius
      queue_csr(CSR_SPARE, 11'h7ff);
      queue_frame(11'd3, 11'd3, 4'd1, 0, 4, 0, 0);
      queue_frame(11'd0, 11'd0, 4'd0, 100, -1, 0, 0);
      queue_frame(11'd1, 11'd1, 4'd15, 100, -1, 0, 100);

      while (total_items < 1200) begin
         case ($urandom_range(3))
            0: density = 3;
            1: density = 15;
            2: density = 40;
            default: density = 85;
         endcase
         w_pick = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
         h_pick = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         r_pick = $urandom_range(9);
         if (r_pick < 6) r_pick = $urandom_range(0, 2);
         else if (r_pick < 9) r_pick = $urandom_range(3, 8);
         else r_pick = $urandom_range(9, 15);
         if ($urandom_range(15) == 0) queue_csr(CSR_SPARE, CFG_WIDTH'($urandom_range(2047)));
         queue_frame(CFG_WIDTH'(w_pick), CFG_WIDTH'(h_pick), RADIUS_WIDTH'(r_pick),
                     density, -1,
                     ($urandom_range(4) == 0) ? 30 : 0, ($urandom_range(2) == 0) ? 50 : 0);
      end
      cycle_limit = 4 * limit_budget + 50000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!(stim_done && awaited_cells.size() == 0) && cycle_count < cycle_limit)
         @(posedge clock);
      timed_out = cycle_count >= cycle_limit;
      if (timed_out) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_cells.size());
         $display("FAIL occupancy_grid_disk_inflation");
      end else begin
         repeat (QUIET_CYCLES) @(posedge clock);
         $display("ran %0d grid transactions in %0d frames, %0d register writes",
                  total_items, frames_queued, csr_writes);
         $display("checked %0d cell reports, %0d frames closed, %0d failures",
                  cells_checked, frames_done, fail_count);
         if (fail_count == 0 && awaited_cells.size() == 0)
            $display("PASS occupancy_grid_disk_inflation");
         else
            $display("FAIL occupancy_grid_disk_inflation");
      end
      $finish;
   end

endmodule
